FILE: hdl/crpe_pkg.sv
// Shared types, widths and constants of the Catmull-Rom point evaluator.
// No dependencies; every other file imports it.
package crpe_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int BANKS      = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = ADDR_W - BANK_SEL_W;
  localparam int BANK_DEPTH = MAX_POINTS / BANKS;
  localparam int AXES       = 3;
  localparam int STAGES     = 8;

  localparam int COORD_W = 32;
  localparam int T_W     = 18;
  localparam int FRAC_W  = 16;
  localparam int A_W     = COORD_W + 1;
  localparam int P1D_W   = COORD_W + 1;
  localparam int BC_W    = COORD_W + 4;
  localparam int PROD1_W = BC_W + T_W;
  localparam int U_W     = BC_W + 1;
  localparam int PROD2_W = U_W + T_W;
  localparam int V_W     = U_W + 1;
  localparam int PROD3_W = V_W + T_W;
  localparam int W_W     = V_W + 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [T_W-1:0]     tparam_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  function automatic coord_t axis_of(point_t p, int unsigned ax);
    logic [AXES*COORD_W-1:0] flat;
    flat = p;
    return coord_t'(flat[(AXES - 1 - ax) * COORD_W +: COORD_W]);
  endfunction

endpackage

FILE: hdl/crpe_if.sv
// Valid/ready channel interfaces of the Catmull-Rom point evaluator.
// Depends on crpe_pkg for field types.
interface crpe_in_if
  import crpe_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  op_t                  op;
  logic [IDX_W-1:0]     point_index;
  coord_t               in_x;
  coord_t               in_y;
  coord_t               in_z;
  tparam_t              t_param;

  modport source (output valid, op, point_index, in_x, in_y, in_z, t_param, input ready);
  modport sink   (input valid, op, point_index, in_x, in_y, in_z, t_param, output ready);
endinterface

interface crpe_out_if
  import crpe_pkg::*;
  ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   interpolated;

  modport source (output valid, out_x, out_y, out_z, interpolated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, interpolated, output ready);
endinterface

FILE: hdl/catmull_rom_point_evaluator_top.sv
// Catmull-Rom point evaluator: banked point table and eight-stage cubic pipeline.
// Depends on crpe_pkg and the channel interfaces in crpe_if.sv.
//
// Usage:
//   req carries one item per transfer. op = write stores (in_x, in_y, in_z) at
//   point_index and yields no result. op = eval starts the segment at
//   point_index with parameter t_param and yields one result on rsp.
//   cfg_wr_en/cfg_wr_data load point_count; change it only while idle.
//   The table sits in four banks (index mod 4), each with one write and one
//   read port, so the four points of a segment are read in the same cycle.
//   Throughput: one item per cycle while rsp does not stall. An eval passes
//   through the registered stages in order: bank read, coefficient stage,
//   then three multiply and three round/add stages per axis, and rsp.valid
//   rises once it reaches the last. A write is visible to the very next item.
//   When rsp stalls, results back up stage by stage; req.ready drops only
//   once all eight stages are full.
//   Reset clears point_count and the pipeline; table contents are undefined
//   until written. Boundary segments return a stored point with
//   interpolated = 0.
module catmull_rom_point_evaluator_top
  import crpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  crpe_in_if.sink          req,
  crpe_out_if.source       rsp
);

  logic [CNT_W-1:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  // pipeline flow control
  logic [STAGES:1] vld;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !vld[STAGES] || rsp.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req.ready = en[1];

  logic take;
  assign take = req.valid && req.ready;

  // stage 0: boundary decode and bank addressing
  logic [CNT_W-1:0]  n_pts;
  logic [CNT_W-1:0]  idx_ext;
  logic              zero_s0;
  logic              interp_s0;
  logic [ADDR_W-1:0] ret_idx;
  logic [ADDR_W-1:0] base_s0;

  always_comb begin
    n_pts     = (point_count > MAX_CNT) ? MAX_CNT : point_count;
    idx_ext   = CNT_W'(req.point_index);
    zero_s0   = (n_pts == '0);
    interp_s0 = 1'b0;
    priority if (zero_s0) begin
      ret_idx = '0;
    end else if (idx_ext >= n_pts) begin
      ret_idx = ADDR_W'(n_pts - CNT_W'(1));
    end else if (idx_ext == '0 || (idx_ext + CNT_W'(2)) >= n_pts) begin
      ret_idx = ADDR_W'(req.point_index);
    end else begin
      ret_idx   = ADDR_W'(req.point_index);
      interp_s0 = 1'b1;
    end
    // window is base .. base+3, the returned point sits at base+1
    base_s0 = ret_idx - ADDR_W'(1);
  end

  logic [BANK_AW-1:0] rd_addr [BANKS];

  always_comb begin
    logic [BANK_SEL_W-1:0] offset;
    logic [ADDR_W-1:0]     win;
    for (int b = 0; b < BANKS; b++) begin
      offset     = BANK_SEL_W'(b) - base_s0[BANK_SEL_W-1:0];
      win        = base_s0 + ADDR_W'(offset);
      rd_addr[b] = win[ADDR_W-1:BANK_SEL_W];
    end
  end

  logic                  wr_en;
  logic [BANK_SEL_W-1:0] wr_bank;
  logic [BANK_AW-1:0]    wr_addr;
  point_t                wr_point;

  assign wr_en    = take && (req.op == OP_WRITE) && (CNT_W'(req.point_index) < MAX_CNT);
  assign wr_bank  = req.point_index[BANK_SEL_W-1:0];
  assign wr_addr  = req.point_index[ADDR_W-1:BANK_SEL_W];
  assign wr_point = '{x: req.in_x, y: req.in_y, z: req.in_z};

  // point table, one bank per index mod 4
  point_t bank_mem [BANKS][BANK_DEPTH];
  point_t rd_s1    [BANKS];

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (wr_en && wr_bank == BANK_SEL_W'(b)) begin
        bank_mem[b][wr_addr] <= wr_point;
      end
      if (en[1]) begin
        rd_s1[b] <= bank_mem[b][rd_addr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= take && (req.op == OP_EVAL);
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage payload registers
  logic [BANK_SEL_W-1:0]      base_s1;
  logic                       interp_s1, zero_s1;
  tparam_t                    t_s1;

  logic signed [A_W-1:0]      a_s2   [AXES];
  logic signed [BC_W-1:0]     b_s2   [AXES];
  logic signed [BC_W-1:0]     c_s2   [AXES];
  logic signed [P1D_W-1:0]    p1d_s2 [AXES];
  tparam_t                    t_s2;
  logic                       interp_s2;

  logic signed [PROD1_W-1:0]  prod1_s3 [AXES];
  logic signed [A_W-1:0]      a_s3     [AXES];
  logic signed [BC_W-1:0]     b_s3     [AXES];
  logic signed [P1D_W-1:0]    p1d_s3   [AXES];
  tparam_t                    t_s3;
  logic                       interp_s3;

  logic signed [U_W-1:0]      u_s4   [AXES];
  logic signed [A_W-1:0]      a_s4   [AXES];
  logic signed [P1D_W-1:0]    p1d_s4 [AXES];
  tparam_t                    t_s4;
  logic                       interp_s4;

  logic signed [PROD2_W-1:0]  prod2_s5 [AXES];
  logic signed [A_W-1:0]      a_s5     [AXES];
  logic signed [P1D_W-1:0]    p1d_s5   [AXES];
  tparam_t                    t_s5;
  logic                       interp_s5;

  logic signed [V_W-1:0]      v_s6   [AXES];
  logic signed [P1D_W-1:0]    p1d_s6 [AXES];
  tparam_t                    t_s6;
  logic                       interp_s6;

  logic signed [PROD3_W-1:0]  prod3_s7 [AXES];
  logic signed [P1D_W-1:0]    p1d_s7   [AXES];
  logic                       interp_s7;

  coord_t                     res_s8 [AXES];
  logic                       interp_s8;

  // stage 1 -> 2: rotate bank outputs into p0..p3, form coefficients
  logic signed [A_W-1:0]   a_c   [AXES];
  logic signed [BC_W-1:0]  b_c   [AXES];
  logic signed [BC_W-1:0]  c_c   [AXES];
  logic signed [P1D_W-1:0] p1d_c [AXES];

  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    coord_t                m [BANKS];
    for (int ax = 0; ax < AXES; ax++) begin
      for (int k = 0; k < BANKS; k++) begin
        sel  = base_s1 + BANK_SEL_W'(k);
        m[k] = axis_of(rd_s1[sel], ax);
      end
      // outside the cubic only p1 counts; zero table returns zero
      if (!interp_s1) begin
        m[0] = '0;
        m[2] = '0;
        m[3] = '0;
      end
      if (zero_s1) begin
        m[1] = '0;
      end
      a_c[ax]   = A_W'(m[2]) - A_W'(m[0]);
      b_c[ax]   = (BC_W'(m[0]) <<< 1) - (BC_W'(m[1]) <<< 2) - BC_W'(m[1])
                + (BC_W'(m[2]) <<< 2) - BC_W'(m[3]);
      c_c[ax]   = BC_W'(m[3]) - BC_W'(m[0]) + (BC_W'(m[1]) <<< 1) + BC_W'(m[1])
                - (BC_W'(m[2]) <<< 1) - BC_W'(m[2]);
      p1d_c[ax] = P1D_W'(m[1]) <<< 1;
    end
  end

  // round-half-up shifts and the final saturation
  logic signed [PROD1_W-1:0] r1_c [AXES];
  logic signed [PROD2_W-1:0] r2_c [AXES];
  logic signed [PROD3_W-1:0] r3_c [AXES];
  coord_t                    sat_c [AXES];

  always_comb begin
    logic signed [W_W-1:0] w;
    logic signed [W_W-1:0] h;
    for (int ax = 0; ax < AXES; ax++) begin
      r1_c[ax] = (prod1_s3[ax] + (PROD1_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      r2_c[ax] = (prod2_s5[ax] + (PROD2_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      r3_c[ax] = (prod3_s7[ax] + (PROD3_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      w = W_W'(r3_c[ax]) + W_W'(p1d_s7[ax]);
      h = (w + W_W'(1)) >>> 1;
      priority if (h > W_W'(COORD_MAX)) begin
        sat_c[ax] = COORD_MAX;
      end else if (h < W_W'(COORD_MIN)) begin
        sat_c[ax] = COORD_MIN;
      end else begin
        sat_c[ax] = coord_t'(h[COORD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      base_s1   <= base_s0[BANK_SEL_W-1:0];
      interp_s1 <= interp_s0;
      zero_s1   <= zero_s0;
      t_s1      <= req.t_param;
    end
    if (en[2]) begin
      a_s2      <= a_c;
      b_s2      <= b_c;
      c_s2      <= c_c;
      p1d_s2    <= p1d_c;
      t_s2      <= interp_s1 ? t_s1 : '0;
      interp_s2 <= interp_s1;
    end
    if (en[3]) begin
      for (int ax = 0; ax < AXES; ax++) begin
        prod1_s3[ax] <= PROD1_W'(c_s2[ax]) * PROD1_W'(t_s2);
      end
      a_s3      <= a_s2;
      b_s3      <= b_s2;
      p1d_s3    <= p1d_s2;
      t_s3      <= t_s2;
      interp_s3 <= interp_s2;
    end
    if (en[4]) begin
      for (int ax = 0; ax < AXES; ax++) begin
        u_s4[ax] <= U_W'(r1_c[ax]) + U_W'(b_s3[ax]);
      end
      a_s4      <= a_s3;
      p1d_s4    <= p1d_s3;
      t_s4      <= t_s3;
      interp_s4 <= interp_s3;
    end
    if (en[5]) begin
      for (int ax = 0; ax < AXES; ax++) begin
        prod2_s5[ax] <= PROD2_W'(u_s4[ax]) * PROD2_W'(t_s4);
      end
      a_s5      <= a_s4;
      p1d_s5    <= p1d_s4;
      t_s5      <= t_s4;
      interp_s5 <= interp_s4;
    end
    if (en[6]) begin
      for (int ax = 0; ax < AXES; ax++) begin
        v_s6[ax] <= V_W'(r2_c[ax]) + V_W'(a_s5[ax]);
      end
      p1d_s6    <= p1d_s5;
      t_s6      <= t_s5;
      interp_s6 <= interp_s5;
    end
    if (en[7]) begin
      for (int ax = 0; ax < AXES; ax++) begin
        prod3_s7[ax] <= PROD3_W'(v_s6[ax]) * PROD3_W'(t_s6);
      end
      p1d_s7    <= p1d_s6;
      interp_s7 <= interp_s6;
    end
    if (en[8]) begin
      res_s8    <= sat_c;
      interp_s8 <= interp_s7;
    end
  end

  assign rsp.valid        = vld[STAGES];
  assign rsp.out_x        = res_s8[0];
  assign rsp.out_y        = res_s8[1];
  assign rsp.out_z        = res_s8[2];
  assign rsp.interpolated = interp_s8;

endmodule

FILE: hdl/crpe_checker.sv
// Port-level checker for the Catmull-Rom point evaluator, with its bind.
// Depends on crpe_pkg; attaches to catmull_rom_point_evaluator_top.
module crpe_checker
  import crpe_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   req_valid,
  input logic   req_ready,
  input logic   rsp_valid,
  input logic   rsp_ready,
  input coord_t rsp_out_x,
  input coord_t rsp_out_y,
  input coord_t rsp_out_z,
  input logic   rsp_interpolated
);

  // reset empties the pipeline and opens the input
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("pipeline not empty after reset");

  // input stalls only while the output is valid and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_ready) |-> (rsp_valid && !rsp_ready))
    else $error("input stalled without output backpressure");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped before transfer");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> ($stable(rsp_out_x) && $stable(rsp_out_y)
                                   && $stable(rsp_out_z) && $stable(rsp_interpolated)))
    else $error("result changed while stalled");

endmodule

bind catmull_rom_point_evaluator_top crpe_checker u_crpe_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_out_x        (rsp.out_x),
  .rsp_out_y        (rsp.out_y),
  .rsp_out_z        (rsp.out_z),
  .rsp_interpolated (rsp.interpolated)
);

FILE: dv/catmull_rom_point_evaluator_top_tb.sv
// Self-checking testbench for catmull_rom_point_evaluator_top: directed and random
// point writes and segment evaluations, checked against a fixed-point spline predictor.
// Depends on crpe_pkg, crpe_if.sv and the RTL top level.
module catmull_rom_point_evaluator_top_tb;
  import crpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   interp;
  } curve_point_t;

  class spline_eval_checker;
    coord_t       px[MAX_POINTS];
    coord_t       py[MAX_POINTS];
    coord_t       pz[MAX_POINTS];
    bit           defined_pt[MAX_POINTS];
    int unsigned  point_count;
    curve_point_t expected_points[$];
    int unsigned  mismatches;

    function new();
      point_count = 0;
      mismatches  = 0;
      foreach (defined_pt[i]) defined_pt[i] = 1'b0;
    endfunction

    function int unsigned live_points();
      return (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
    endfunction

    // Returns an unwritten entry that an evaluation at idx would read, or -1.
    function int missing_point(int idx);
      int unsigned n;
      n = live_points();
      if (n == 0) return -1;
      if (idx >= n) return defined_pt[n-1] ? -1 : int'(n - 1);
      if (idx == 0 || idx + 2 >= n) return defined_pt[idx] ? -1 : idx;
      for (int k = idx - 1; k <= idx + 2; k++) begin
        if (!defined_pt[k]) return k;
      end
      return -1;
    endfunction

    function longint round_shift(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function coord_t eval_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3, tparam_t t);
      longint p0, p1, p2, p3, tt, a, b, c, u, v, w, r;
      p0 = c0;
      p1 = c1;
      p2 = c2;
      p3 = c3;
      tt = t;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + 3 * p1 - 3 * p2 + p3;
      u = round_shift(c * tt, FRAC_W) + b;
      v = round_shift(u * tt, FRAC_W) + a;
      w = round_shift(v * tt, FRAC_W) + 2 * p1;
      r = round_shift(w, 1);
      if (r > longint'(COORD_MAX)) r = COORD_MAX;
      if (r < longint'(COORD_MIN)) r = COORD_MIN;
      return coord_t'(r);
    endfunction

    function void take_item(op_t op, int idx, coord_t x, coord_t y, coord_t z, tparam_t t);
      int unsigned  n;
      int           k;
      curve_point_t r;
      if (op == OP_WRITE) begin
        px[idx] = x;
        py[idx] = y;
        pz[idx] = z;
        defined_pt[idx] = 1'b1;
        return;
      end
      n = live_points();
      r.interp = 1'b0;
      if (n == 0) begin
        r.x = '0;
        r.y = '0;
        r.z = '0;
      end else if (idx >= n || idx == 0 || idx + 2 >= n) begin
        k = (idx >= n) ? int'(n - 1) : idx;
        r.x = px[k];
        r.y = py[k];
        r.z = pz[k];
      end else begin
        r.x = eval_axis(px[idx-1], px[idx], px[idx+1], px[idx+2], t);
        r.y = eval_axis(py[idx-1], py[idx], py[idx+1], py[idx+2], t);
        r.z = eval_axis(pz[idx-1], pz[idx], pz[idx+1], pz[idx+2], t);
        r.interp = 1'b1;
      end
      expected_points.push_back(r);
    endfunction

    function void check_point(coord_t x, coord_t y, coord_t z, logic interp);
      curve_point_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected result transfer: x=%0d y=%0d z=%0d interpolated=%b",
               x, y, z, interp);
        mismatches++;
        return;
      end
      e = expected_points.pop_front();
      if (x !== e.x) begin
        $error("out_x: expected %0d, actual %0d", e.x, x);
        mismatches++;
      end
      if (y !== e.y) begin
        $error("out_y: expected %0d, actual %0d", e.y, y);
        mismatches++;
      end
      if (z !== e.z) begin
        $error("out_z: expected %0d, actual %0d", e.z, z);
        mismatches++;
      end
      if (interp !== e.interp) begin
        $error("interpolated: expected %b, actual %b", e.interp, interp);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  bit               steady;

  crpe_in_if  req ();
  crpe_out_if rsp ();

  spline_eval_checker sb;

  catmull_rom_point_evaluator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req.sink),
    .rsp         (rsp.source)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check_point(rsp.out_x, rsp.out_y, rsp.out_z, rsp.interpolated);
    end
    rsp.ready <= steady || ($urandom_range(99) >= 30);
  end

  task automatic send_item(op_t op, int idx, coord_t x, coord_t y, coord_t z, tparam_t t);
    while (!steady && $urandom_range(99) < 30) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.op          <= op;
    req.point_index <= idx[IDX_W-1:0];
    req.in_x        <= x;
    req.in_y        <= y;
    req.in_z        <= z;
    req.t_param     <= t;
    do @(posedge clk); while (!req.ready);
    sb.take_item(op, idx, x, y, z, t);
  endtask

  task automatic wait_results_drained();
    req.valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic load_point_count(int unsigned v);
    wait_results_drained();
    repeat (12) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.point_count = v;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'($urandom_range(0, 1 << 21)) - coord_t'(1 << 20);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tparam_t rand_t();
    case ($urandom_range(7))
      0: return tparam_t'(-131072);
      1: return tparam_t'(131071);
      2: return tparam_t'(65536);
      3: return '0;
      default: return tparam_t'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    op_t         op;
    int          idx;
    int          miss;
    int unsigned n;
    n   = sb.live_points();
    op  = ($urandom_range(99) < 40) ? OP_WRITE : OP_EVAL;
    idx = (n > 0 && $urandom_range(3) != 0) ? int'($urandom_range(n - 1)) :
          int'($urandom_range(MAX_POINTS - 1));
    if (op == OP_EVAL) begin
      miss = sb.missing_point(idx);
      if (miss >= 0) begin
        op  = OP_WRITE;
        idx = miss;
      end
    end
    send_item(op, idx, rand_coord(), rand_coord(), rand_coord(), rand_t());
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned phase_counts[10];
    sb = new();
    steady          = 1'b0;
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    req.valid       <= 1'b0;
    req.op          <= OP_WRITE;
    req.point_index <= '0;
    req.in_x        <= '0;
    req.in_y        <= '0;
    req.in_z        <= '0;
    req.t_param     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send_item(OP_EVAL, 0, COORD_MAX, COORD_MIN, '1, '0);
    send_item(OP_EVAL, MAX_POINTS - 1, '0, '0, '0, tparam_t'(-131072));

    send_item(OP_WRITE, 0, COORD_MAX, COORD_MIN, '0, '1);
    send_item(OP_WRITE, 1, COORD_MIN, COORD_MAX, '1, '0);
    send_item(OP_WRITE, 2, COORD_MAX, COORD_MIN, coord_t'(1), '0);
    send_item(OP_WRITE, 3, COORD_MIN, COORD_MAX, COORD_MAX, '0);
    send_item(OP_WRITE, 4, '0, '1, COORD_MIN, '0);
    send_item(OP_WRITE, 5, coord_t'(32'h0003_8000), coord_t'(-32'sd98304), rand_coord(), '0);
    send_item(OP_WRITE, 6, rand_coord(), rand_coord(), rand_coord(), '0);
    send_item(OP_WRITE, 7, rand_coord(), rand_coord(), rand_coord(), '0);
    send_item(OP_WRITE, MAX_POINTS - 1, rand_coord(), rand_coord(), rand_coord(), '0);

    load_point_count(8);
    send_item(OP_EVAL, 0, '0, '0, '0, tparam_t'(65536));
    send_item(OP_EVAL, 7, '0, '0, '0, tparam_t'(65536));
    send_item(OP_EVAL, 6, '0, '0, '0, tparam_t'(65536));
    send_item(OP_EVAL, 9, '0, '0, '0, '0);
    send_item(OP_EVAL, MAX_POINTS - 1, '0, '0, '0, '0);
    send_item(OP_EVAL, 1, '0, '0, '0, tparam_t'(-131072));
    send_item(OP_EVAL, 1, '0, '0, '0, tparam_t'(131071));
    send_item(OP_EVAL, 2, '0, '0, '0, tparam_t'(65536));
    send_item(OP_EVAL, 3, '0, '0, '0, '0);
    send_item(OP_EVAL, 4, '0, '0, '0, '1);
    send_item(OP_EVAL, 5, '0, '0, '0, tparam_t'(32768));

    // count above the table size
    load_point_count(127);
    send_item(OP_EVAL, MAX_POINTS - 1, '0, '0, '0, tparam_t'(65536));
    send_item(OP_EVAL, 0, '0, '0, '0, '0);

    phase_counts = '{64, 4, 3, 1, 2, 100, 127, 0, 64, 0};
    phase_counts[9] = $urandom_range(127);
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph == 8);
      load_point_count(phase_counts[ph]);
      for (int i = 0; i < 40; i++) begin
        if (ph == 4 && i == 20) wait_results_drained();
        send_random_item();
      end
    end
    steady = 1'b0;

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
